// ===== rtl/chev_pkg.sv =====
`default_nettype none

package chev_pkg;

  localparam int QW       = 16;
  localparam int TW       = 17;
  localparam int CW       = 20;
  localparam int DW       = 19;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOPE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_SLOPE   = 2'd3;

  typedef struct packed {
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [DW-1:0] d;
    logic                 flat;
  } coef_t;

endpackage

`default_nettype wire

// ===== rtl/chev_coef.sv =====
`default_nettype none

module chev_coef
  import chev_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [QW-1:0]        cfg_wdata_i,
  output coef_t                     coef_o
);

  logic [QW-1:0] start_value_q, end_value_q, start_slope_q, end_slope_q;
  logic signed [CW-1:0] s_x, e_x, ds_x, de_x, diff, c_full, d_full;
  coef_t coef_d, coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= '0;
      end_value_q   <= '0;
      start_slope_q <= '0;
      end_slope_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_VALUE: start_value_q <= cfg_wdata_i;
        REG_END_VALUE:   end_value_q   <= cfg_wdata_i;
        REG_START_SLOPE: start_slope_q <= cfg_wdata_i;
        REG_END_SLOPE:   end_slope_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_x  = {{(CW-QW){start_value_q[QW-1]}}, start_value_q};
  assign e_x  = {{(CW-QW){end_value_q[QW-1]}}, end_value_q};
  assign ds_x = {{(CW-QW){start_slope_q[QW-1]}}, start_slope_q};
  assign de_x = {{(CW-QW){end_slope_q[QW-1]}}, end_slope_q};

  assign diff   = e_x - s_x;
  assign c_full = diff + diff + diff - (de_x + ds_x + ds_x);
  assign d_full = (s_x - e_x) + (s_x - e_x) + ds_x + de_x;

  always_comb begin
    coef_d.a    = start_value_q;
    coef_d.b    = start_slope_q;
    coef_d.c    = c_full;
    coef_d.d    = d_full[DW-1:0];
    coef_d.flat = (start_value_q == '0) && (start_slope_q == '0) &&
                  (c_full == '0) && (d_full == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{a: '0, b: '0, c: '0, d: '0, flat: 1'b1};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ===== rtl/chev_pipe.sv =====
`default_nettype none

module chev_pipe
  import chev_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire coef_t          coef_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [TW-1:0]  param_t_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [QW-1:0]       curve_value_o,
  output logic [QW-1:0]       curve_slope_o,
  output logic                value_saturated_o,
  output logic                is_flat_o
);

  localparam int NStage = 8;
  localparam logic signed [57:0] HalfQ = 58'sd2147483648;
  localparam logic signed [59:0] HalfV = 60'sd2147483648;
  localparam logic signed [27:0] QMax  = 28'sd32767;
  localparam logic signed [27:0] QMin  = -28'sd32768;

  function automatic logic [QW:0] clip16(input logic signed [27:0] v);
    logic [QW:0] r;
    if (v > QMax) begin
      r = {1'b1, 16'h7fff};
    end else if (v < QMin) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[QW-1:0]};
    end
    return r;
  endfunction

  logic [NStage-1:0] vld_q, vld_d, en;

  // per-stage load enables, bubbles collapse
  always_comb begin
    en[NStage-1] = ~vld_q[NStage-1] | out_ready_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d    = vld_q;
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NStage; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStage-1];

  logic signed [QW-1:0] ca, cb;
  logic signed [CW-1:0] cc;
  logic signed [DW-1:0] cd;
  assign ca = coef_i.a;
  assign cb = coef_i.b;
  assign cc = coef_i.c;
  assign cd = coef_i.d;

  // stage 0: sample
  logic [TW-1:0] t0_q, t1_q, t2_q, t3_q, t4_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) t0_q <= param_t_i;
  end

  // stage 1: d * t
  logic signed [TW:0] t0s, t2s, t5s;
  logic signed [36:0] dt_d, dt_q;
  assign t0s  = {1'b0, t0_q};
  assign dt_d = cd * t0s;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dt_q <= dt_d;
      t1_q <= t0_q;
    end
  end

  // stage 2: inner horner terms for value and slope
  logic signed [37:0] s2_d, s2_q;
  logic signed [39:0] dtx, p_d, p_q;
  assign s2_d = $signed({{2{cc[CW-1]}}, cc, 16'b0}) + $signed({dt_q[36], dt_q});
  assign dtx  = $signed({{3{dt_q[36]}}, dt_q});
  assign p_d  = $signed({{3{cc[CW-1]}}, cc, 17'b0}) + dtx + (dtx <<< 1);
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q <= s2_d;
      p_q  <= p_d;
      t2_q <= t1_q;
    end
  end

  // stage 3: split products by t
  logic signed [39:0] sh_d, sh_q;
  logic signed [34:0] sl_d, sl_q, pl_d, pl_q;
  logic signed [41:0] ph_d, ph_q;
  assign t2s  = {1'b0, t2_q};
  assign sh_d = $signed(s2_q[37:16]) * t2s;
  assign sl_d = $signed({1'b0, s2_q[15:0]}) * t2s;
  assign ph_d = $signed(p_q[39:16]) * t2s;
  assign pl_d = $signed({1'b0, p_q[15:0]}) * t2s;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sh_q <= sh_d;
      sl_q <= sl_d;
      ph_q <= ph_d;
      pl_q <= pl_d;
      t3_q <= t2_q;
    end
  end

  // stage 4: recombine, slope rounded
  logic signed [55:0] s1_d, s1_q;
  logic signed [57:0] q_d;
  logic signed [25:0] slo4_q, slo5_q, slo6_q;
  assign s1_d = $signed({{8{cb[QW-1]}}, cb, 32'b0}) + $signed({sh_q, 16'b0})
              + $signed({{21{sl_q[34]}}, sl_q});
  assign q_d  = $signed({{10{cb[QW-1]}}, cb, 32'b0}) + $signed({ph_q, 16'b0})
              + $signed({{23{pl_q[34]}}, pl_q}) + HalfQ;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s1_q   <= s1_d;
      slo4_q <= q_d[57:32];
      t4_q   <= t3_q;
    end
  end

  // stage 5: outer products, high part and fraction
  logic signed [41:0] hh_d, hh_q;
  logic signed [34:0] hl_d, hl_q, lt_d, lt_q;
  assign t5s  = {1'b0, t4_q};
  assign hh_d = $signed(s1_q[55:32]) * t5s;
  assign hl_d = $signed({1'b0, s1_q[31:16]}) * t5s;
  assign lt_d = $signed({1'b0, s1_q[15:0]}) * t5s;
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lt_q   <= lt_d;
      slo5_q <= slo4_q;
    end
  end

  // stage 6: value sum, rounded
  logic signed [59:0] v_d;
  logic signed [27:0] val_q;
  assign v_d = $signed({{12{ca[QW-1]}}, ca, 32'b0}) + $signed({{2{hh_q[41]}}, hh_q, 16'b0})
             + $signed({{25{hl_q[34]}}, hl_q}) + HalfV + $signed({41'b0, lt_q[34:16]});
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      val_q  <= v_d[59:32];
      slo6_q <= slo5_q;
    end
  end

  // stage 7: saturate into output register
  logic [QW:0] vclip, sclip;
  assign vclip = clip16(val_q);
  assign sclip = clip16({{2{slo6_q[25]}}, slo6_q});
  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      curve_value_o     <= vclip[QW-1:0];
      curve_slope_o     <= sclip[QW-1:0];
      value_saturated_o <= vclip[QW] | sclip[QW];
      is_flat_o         <= coef_i.flat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cubic_hermite_evaluator.sv =====
`default_nettype none

// Cubic Hermite segment evaluator. Write start value, end value, start slope and
// end slope (signed Q8.8) through the cfg port while no request is in flight; each
// param_t request (unsigned Q1.16) returns the segment value and slope rounded half
// up and saturated to Q8.8, a clip flag and a flat flag. The eight-stage pipeline,
// with every wide multiply split into partial products of at most 24x18, takes one
// request per cycle unless stalled, moving it through the stages in order; a result
// held at the output stalls only as far back as the pipeline is full.

module cubic_hermite_evaluator
  import chev_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [QW-1:0]        cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TW-1:0]        param_t_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [QW-1:0]             curve_value_o,
  output logic [QW-1:0]             curve_slope_o,
  output logic                      value_saturated_o,
  output logic                      is_flat_o
);

  coef_t coef;

  chev_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  chev_pipe u_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coef_i            (coef),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .param_t_i         (param_t_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .curve_value_o     (curve_value_o),
    .curve_slope_o     (curve_slope_o),
    .value_saturated_o (value_saturated_o),
    .is_flat_o         (is_flat_o)
  );

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output not blocked");

  a_flat_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_flat_o) |-> (curve_value_o == '0 && curve_slope_o == '0 &&
                                     !value_saturated_o))
    else $error("flat segment gave nonzero result");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_saturated_o) |->
      (curve_value_o == 16'h7fff || curve_value_o == 16'h8000 ||
       curve_slope_o == 16'h7fff || curve_slope_o == 16'h8000))
    else $error("clip flag without a limit value");

endmodule

`default_nettype wire

// ===== tb/sv/tb_cubic_hermite_evaluator.sv =====
module tb_cubic_hermite_evaluator;
  import chev_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [QW-1:0] value;
    logic [QW-1:0] slope;
    logic          sat;
    logic          flat;
  } hermite_point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [QW-1:0]        cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [TW-1:0]        param_t_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [QW-1:0]        curve_value_o;
  logic [QW-1:0]        curve_slope_o;
  logic                 value_saturated_o;
  logic                 is_flat_o;

  logic signed [QW-1:0] seg_start = '0;
  logic signed [QW-1:0] seg_end = '0;
  logic signed [QW-1:0] seg_start_slope = '0;
  logic signed [QW-1:0] seg_end_slope = '0;

  logic [TW-1:0]  param_q[$];
  hermite_point_t point_q[$];
  int             fail_count = 0;
  bit             idle_en = 1'b1;
  bit             long_hold_go = 1'b0;
  bit             long_hold_done = 1'b0;
  int             gap_cnt = 0;
  int             stall_cnt = 0;
  int             hold_cnt = 0;
  int             quiet_cycles = 0;

  cubic_hermite_evaluator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .param_t_i        (param_t_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .curve_value_o    (curve_value_o),
    .curve_slope_o    (curve_slope_o),
    .value_saturated_o(value_saturated_o),
    .is_flat_o        (is_flat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic hermite_point_t eval_hermite(logic [TW-1:0] t);
    logic signed [127:0] a, b, c, d, e, de, tt, vx, sx;
    hermite_point_t pt;
    a  = 128'(seg_start);
    e  = 128'(seg_end);
    b  = 128'(seg_start_slope);
    de = 128'(seg_end_slope);
    tt = 128'(t);
    c  = 3 * (e - a) - (de + 2 * b);
    d  = 2 * (a - e) + b + de;
    // value scaled by 2^48, slope by 2^32, rounded half up
    vx = (a <<< 48) + ((b * tt) <<< 32) + ((c * tt * tt) <<< 16) + d * tt * tt * tt
       + (128'sd1 <<< 47);
    vx = vx >>> 48;
    sx = (b <<< 32) + ((2 * c * tt) <<< 16) + 3 * d * tt * tt + (128'sd1 <<< 31);
    sx = sx >>> 32;
    pt.sat = 1'b0;
    if (vx > 32767) begin
      vx = 32767;
      pt.sat = 1'b1;
    end else if (vx < -32768) begin
      vx = -32768;
      pt.sat = 1'b1;
    end
    if (sx > 32767) begin
      sx = 32767;
      pt.sat = 1'b1;
    end else if (sx < -32768) begin
      sx = -32768;
      pt.sat = 1'b1;
    end
    pt.value = vx[QW-1:0];
    pt.slope = sx[QW-1:0];
    pt.flat  = (a == 0) && (b == 0) && (c == 0) && (d == 0);
    return pt;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      param_t_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        point_q = {point_q, eval_hermite(param_t_i)};
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_cnt != 0) begin
          gap_cnt    <= gap_cnt - 1;
          in_valid_i <= 1'b0;
        end else if (param_q.size() != 0) begin
          if (idle_en && $urandom_range(0, 7) == 0) begin
            gap_cnt    <= $urandom_range(0, 11);
            in_valid_i <= 1'b0;
          end else begin
            in_valid_i <= 1'b1;
            param_t_i  <= param_q.pop_front();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    hermite_point_t want;
    if (!rst_ni) begin
      out_ready_i    <= 1'b0;
      stall_cnt      <= 0;
      hold_cnt       <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (point_q.size() == 0) begin
          $error("result with nothing expected: value %0d slope %0d",
                 $signed(curve_value_o), $signed(curve_slope_o));
          fail_count++;
        end else begin
          want = point_q.pop_front();
          if (curve_value_o !== want.value) begin
            $error("curve_value: expected %0d, got %0d", $signed(want.value),
                   $signed(curve_value_o));
            fail_count++;
          end
          if (curve_slope_o !== want.slope) begin
            $error("curve_slope: expected %0d, got %0d", $signed(want.slope),
                   $signed(curve_slope_o));
            fail_count++;
          end
          if (value_saturated_o !== want.sat) begin
            $error("value_saturated: expected %0b, got %0b", want.sat, value_saturated_o);
            fail_count++;
          end
          if (is_flat_o !== want.flat) begin
            $error("is_flat: expected %0b, got %0b", want.flat, is_flat_o);
            fail_count++;
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_cnt       <= LONG_HOLD;
        out_ready_i    <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_cnt   <= $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_START_VALUE: seg_start = val;
      REG_END_VALUE:   seg_end = val;
      REG_START_SLOPE: seg_start_slope = val;
      default:         seg_end_slope = val;
    endcase
  endtask

  task automatic set_segment(input logic [QW-1:0] s, input logic [QW-1:0] e,
                             input logic [QW-1:0] ds, input logic [QW-1:0] de);
    write_reg(REG_START_VALUE, s);
    write_reg(REG_END_VALUE, e);
    write_reg(REG_START_SLOPE, ds);
    write_reg(REG_END_SLOPE, de);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  // wait until every request is in and every result is out
  task automatic drain();
    @(negedge clk_i);
    while (param_q.size() != 0 || in_valid_i || point_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [QW-1:0] rand_word(int mode);
    logic [QW-1:0] w;
    case (mode)
      0: w = 16'($urandom);
      1: w = 16'($urandom_range(0, 4095) - 2048);
      default: begin
        case ($urandom_range(0, 4))
          0: w = 16'h7fff;
          1: w = 16'h8000;
          2: w = 16'h0000;
          3: w = 16'hffff;
          default: w = 16'h0001;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [TW-1:0] rand_param();
    logic [31:0] r;
    logic [TW-1:0] t;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      t = TW'($urandom_range(0, 65536));
    end else if (r < 8) begin
      r = $urandom;
      t = r[TW-1:0];
    end else if (r == 8) begin
      case ($urandom_range(0, 2))
        0: t = 17'd0;
        1: t = 17'd65536;
        default: t = 17'd131071;
      endcase
    end else begin
      t = TW'($urandom_range(65536, 131071));
    end
    return t;
  endfunction

  initial begin
    int mode;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset segment is flat
    param_q = '{17'd0, 17'd65536, 17'd131071, 17'd1};
    drain();

    set_segment(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    param_q = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd131071};
    drain();

    set_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    param_q = '{17'd0, 17'd65536, 17'd131071};
    drain();

    set_segment(16'h0100, 16'h0200, 16'h0000, 16'h0000);
    param_q = '{17'd0, 17'd2, 17'd16384, 17'd32768, 17'd49152, 17'd65536, 17'd98304};
    drain();

    // zero value and start slope but not flat
    set_segment(16'h0000, 16'h0000, 16'h0000, 16'h0001);
    param_q = '{17'd32768, 17'd65536, 17'd100000};
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      mode = ph % 3;
      idle_en = (ph < 8);
      set_segment(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode));
      if (ph == 1) begin
        long_hold_go = 1'b1;
      end
      for (int i = 0; i < 125; i++) begin
        param_q = {param_q, rand_param()};
      end
      drain();
    end

    if (fail_count == 0 && point_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== cubic_hermite_evaluator.f =====
rtl/chev_pkg.sv
rtl/chev_coef.sv
rtl/chev_pipe.sv
rtl/cubic_hermite_evaluator.sv
tb/sv/tb_cubic_hermite_evaluator.sv
